### src/quaternion_normalize_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion normalizer
// Same-cycle and next-cycle implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_NORMALIZE_TOP_ASSERT_SVH
`define QUATERNION_NORMALIZE_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define QN_ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("quaternion_normalize_top: implication check failed");

// ante implies cons in the next cycle
`define QN_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("quaternion_normalize_top: next-cycle check failed");

`endif

### src/qn_pkg.sv
// ----------------------------------------------------------------------------
// qn_pkg
// Shared constants and types of the quaternion normalizer.
// ----------------------------------------------------------------------------
package qn_pkg;

    // default component width, Q4.12 in and Q1.14 out at 16 bits
    localparam int QN_COMPONENT_WIDTH = 16;

    // per-beat side information carried along the pipeline
    typedef struct packed {
        logic [3:0] neg;
        logic       zero;
    } qn_side_t;

endpackage

### src/qn_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// qn_isqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qn_isqrt_pipe #(
    parameter int K = 17
) (
    input  logic           clk,
    input  logic           en,
    input  logic [2*K-1:0] val_in,
    output logic [K-1:0]   root_out,
    output logic [K+1:0]   rem_out
);

    logic [K+1:0]   rem_reg  [K];
    logic [K-1:0]   root_reg [K];
    logic [2*K-1:0] bits_reg [K];

    for (genvar i = 0; i < K; i++) begin : g_stage
        logic [K+1:0]   prev_rem;
        logic [K-1:0]   prev_root;
        logic [2*K-1:0] prev_bits;
        logic [K+1:0]   cand;
        logic [K+1:0]   trial;
        logic           ge;

        if (i == 0) begin : g_first
            assign prev_rem  = '0;
            assign prev_root = '0;
            assign prev_bits = val_in;
        end else begin : g_next
            assign prev_rem  = rem_reg[i-1];
            assign prev_root = root_reg[i-1];
            assign prev_bits = bits_reg[i-1];
        end

        // bring down the next two bits and try root*4+1
        assign cand  = {prev_rem[K-1:0], prev_bits[2*K-1:2*K-2]};
        assign trial = {prev_root, 2'b01};
        assign ge    = (cand >= trial);

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[i]  <= ge ? (cand - trial) : cand;
                root_reg[i] <= {prev_root[K-2:0], ge};
                bits_reg[i] <= {prev_bits[2*K-3:0], 2'b00};
            end
        end
    end

    assign root_out = root_reg[K-1];
    assign rem_out  = rem_reg[K-1];

endmodule

### src/qn_lane.sv
// ----------------------------------------------------------------------------
// qn_lane
// One normalized component: restoring division of c^2 * 2^(2W-2) by the
// sum of squares, then a square root and a final halving to round.
// ----------------------------------------------------------------------------
module qn_lane #(
    parameter int W = 16
) (
    input  logic           clk,
    input  logic           en,
    input  logic [2*W-2:0] sq_in,
    input  logic [2*W:0]   sum_in,
    output logic [W-1:0]   unit_out
);

    localparam int D = 2 * W - 1;

    logic [2*W:0]   rem_reg [D];
    logic [2*W-2:0] quo_reg [D];
    logic [2*W:0]   div_reg [D];
    logic [W-1:0]   root;
    logic [W+1:0]   root_rem;
    logic [W:0]     root_inc;

    for (genvar j = 0; j < D; j++) begin : g_div
        logic [2*W+1:0] cand;
        logic [2*W-2:0] prev_quo;
        logic [2*W:0]   prev_div;
        logic           ge;

        if (j == 0) begin : g_first
            // c^2 <= S, so the top quotient bit needs no shift
            assign cand     = (2*W+2)'(sq_in);
            assign prev_quo = '0;
            assign prev_div = sum_in;
        end else begin : g_next
            assign cand     = {rem_reg[j-1], 1'b0};
            assign prev_quo = quo_reg[j-1];
            assign prev_div = div_reg[j-1];
        end

        assign ge = (cand >= {1'b0, prev_div});

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[j] <= ge ? (2*W+1)'(cand - {1'b0, prev_div}) : (2*W+1)'(cand);
                quo_reg[j] <= {prev_quo[2*W-3:0], ge};
                div_reg[j] <= prev_div;
            end
        end
    end

    // m = isqrt(floor(c^2 * 2^(2W-2) / S)); result rounds as (m + 1) / 2
    qn_isqrt_pipe #(
        .K (W)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .val_in   ({1'b0, quo_reg[D-1]}),
        .root_out (root),
        .rem_out  (root_rem)
    );

    assign root_inc = {1'b0, root} + (W+1)'(1);
    assign unit_out = root_inc[W:1];

endmodule

### src/quaternion_normalize_top.sv
// ----------------------------------------------------------------------------
// quaternion_normalize_top
// Fixed-point quaternion normalizer with a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one quaternion per beat (x, y, z, w, two's
//   complement, W = COMPONENT_WIDTH bits each). The master channel returns
//   the unit quaternion in Q1.(W-2), the rounded length in the input format
//   (saturated at 2^W - 1) and, on m_tuser, a flag for the all-zero input,
//   whose unit components and length are zero.
//   From input beat to output beat the data pass the abs, square and sum
//   registers, the restoring divider (2*W - 1 stages) and the square root
//   (W stages) in each component lane, and the output registers.
//   Throughput is one beat per cycle while the receiver does not stall.
//   Reset clears the valid bits only; the data registers are not reset.
//   When the receiver stalls a valid output beat, the whole pipeline holds
//   and s_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_normalize_top #(
    parameter int COMPONENT_WIDTH = qn_pkg::QN_COMPONENT_WIDTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // comp_x, comp_y, comp_z, comp_w from bit 0 up, zero padded to bytes
    input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // unit_x, unit_y, unit_z, unit_w, magnitude from bit 0 up, zero padded
    output logic [((5*COMPONENT_WIDTH+7)/8)*8-1:0] m_tdata,
    // zero_length
    output logic m_tuser
);

    import qn_pkg::*;

    localparam int W       = COMPONENT_WIDTH;
    localparam int LL      = 3 * W - 1;
    localparam int OUT_IDX = 3 + LL;
    localparam int OUT_DW  = ((5 * W + 7) / 8) * 8;
    localparam int DLY     = 2 * W - 2;
    localparam int UNIT_ONE = 1 << (W - 2);

    logic                en;
    logic                vld_reg  [OUT_IDX+1];
    qn_side_t            side_reg [OUT_IDX];
    qn_side_t            side_in;

    logic [W-1:0]        comp     [4];
    logic [W-1:0]        abs_in   [4];
    logic [W-1:0]        abs_reg  [4];
    logic [2*W-2:0]      sq_reg   [4];
    logic [2*W-2:0]      sq2_reg  [4];
    logic [2*W:0]        sum_reg;
    logic [W-1:0]        unit_mag [4];

    logic [W:0]          mag_root;
    logic [W+2:0]        mag_rem;
    logic [W+1:0]        mag_rnd;
    logic [W-1:0]        mag_sat;
    logic [W-1:0]        mag_dly_reg [DLY];

    logic signed [W-1:0] unit_reg [4];
    logic [W-1:0]        mag_reg;
    logic                zero_reg;

    // advance everything unless a finished beat is waiting
    assign en       = !vld_reg[OUT_IDX] || m_tready;
    assign s_tready = en;

    for (genvar k = 0; k < 4; k++) begin : g_comp
        logic [2*W-1:0] prod;

        assign comp[k]   = s_tdata[k*W +: W];
        assign abs_in[k] = comp[k][W-1] ? W'(~comp[k] + W'(1)) : comp[k];
        assign side_in.neg[k] = comp[k][W-1];
        assign prod = (2*W)'(abs_reg[k]) * (2*W)'(abs_reg[k]);

        always_ff @(posedge aclk) begin
            if (en) begin
                abs_reg[k] <= abs_in[k];
                sq_reg[k]  <= prod[2*W-2:0];
                sq2_reg[k] <= sq_reg[k];
            end
        end

        qn_lane #(
            .W (W)
        ) u_lane (
            .clk      (aclk),
            .en       (en),
            .sq_in    (sq2_reg[k]),
            .sum_in   (sum_reg),
            .unit_out (unit_mag[k])
        );
    end

    assign side_in.zero = (comp[0] == '0) && (comp[1] == '0) &&
                          (comp[2] == '0) && (comp[3] == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= (2*W+1)'(sq_reg[0]) + (2*W+1)'(sq_reg[1]) +
                       (2*W+1)'(sq_reg[2]) + (2*W+1)'(sq_reg[3]);
        end
    end

    // length: root of S, rounded up when the remainder exceeds the root
    qn_isqrt_pipe #(
        .K (W + 1)
    ) u_mag (
        .clk      (aclk),
        .en       (en),
        .val_in   ({1'b0, sum_reg}),
        .root_out (mag_root),
        .rem_out  (mag_rem)
    );

    assign mag_rnd = (W+2)'(mag_root) + (W+2)'(mag_rem > (W+3)'(mag_root));
    assign mag_sat = (mag_rnd[W+1:W] != 2'b00) ? '1 : mag_rnd[W-1:0];

    for (genvar d = 0; d < DLY; d++) begin : g_mag_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                if (d == 0) begin
                    mag_dly_reg[d] <= mag_sat;
                end else begin
                    mag_dly_reg[d] <= mag_dly_reg[(d == 0) ? 0 : d-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= OUT_IDX; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= OUT_IDX; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < OUT_IDX; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // output register: apply signs, zero the lanes and the length on a zero-length beat
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                if (side_reg[OUT_IDX-1].zero) begin
                    unit_reg[k] <= '0;
                end else if (side_reg[OUT_IDX-1].neg[k]) begin
                    unit_reg[k] <= W'(~unit_mag[k] + W'(1));
                end else begin
                    unit_reg[k] <= unit_mag[k];
                end
            end
            mag_reg  <= side_reg[OUT_IDX-1].zero ? '0 : mag_dly_reg[DLY-1];
            zero_reg <= side_reg[OUT_IDX-1].zero;
        end
    end

    assign m_tvalid = vld_reg[OUT_IDX];
    assign m_tuser  = zero_reg;
    assign m_tdata  = OUT_DW'({mag_reg, unit_reg[3], unit_reg[2], unit_reg[1], unit_reg[0]});

`include "quaternion_normalize_top_assert.svh"

    `QN_ASSERT_IMPLIES(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `QN_ASSERT_NEXT(a_accept_enters_pipe, aclk, aresetn, s_tvalid && s_tready, vld_reg[0])
    `QN_ASSERT_IMPLIES(a_nonzero_has_length, aclk, aresetn, m_tvalid && !zero_reg, mag_reg != '0)
    `QN_ASSERT_IMPLIES(a_unit_in_range, aclk, aresetn, m_tvalid, unit_reg[0] <= UNIT_ONE && unit_reg[0] >= -UNIT_ONE)

endmodule
